/* rtl/vsd_pkg.sv */
// Shared types and constants for the varint stream decoder.
// No dependencies; imported by every module of the block.
package vsd_pkg;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned PAYLOAD_W = 7;
  localparam int unsigned VALUE_W   = 64;
  localparam int unsigned COUNT_W   = 4;
  localparam int unsigned SHIFT_W   = 6;
  localparam int unsigned WORD_W    = 32;
  // value and byte_count packed, padded to whole bytes
  localparam int unsigned OUT_DATA_W = 72;
  localparam int unsigned OUT_PAD_W  = OUT_DATA_W - VALUE_W - COUNT_W;

  localparam int unsigned CONT_POS = 7;

  // Byte limits per mode
  localparam logic [COUNT_W-1:0] LIMIT_32 = 4'd5;
  localparam logic [COUNT_W-1:0] LIMIT_64 = 4'd10;

  typedef enum logic {
    STATUS_OK       = 1'b0,
    STATUS_TOO_LONG = 1'b1
  } vsd_status_t;

  typedef struct packed {
    logic                emit;
    logic [VALUE_W-1:0]  value;
    logic [COUNT_W-1:0]  byte_count;
    vsd_status_t         status;
  } vsd_result_t;

endpackage

/* rtl/vsd_step.sv */
// One decode step: merges a byte into the accumulator and forms the result.
// Purely combinational; depends on vsd_pkg.
module vsd_step
  import vsd_pkg::*;
(
  input  logic [BYTE_W-1:0]  byte_i,
  input  logic [VALUE_W-1:0] acc_i,
  input  logic [COUNT_W-1:0] seen_i,
  input  logic               long_mode_i,
  output logic [VALUE_W-1:0] acc_nxt_o,
  output logic [COUNT_W-1:0] seen_nxt_o,
  output vsd_result_t        result_o
);

  logic [PAYLOAD_W-1:0] payload;
  logic                 cont;
  logic [SHIFT_W:0]     shift_full;
  logic [SHIFT_W-1:0]   shift;
  logic [VALUE_W-1:0]   acc_or;
  logic [COUNT_W-1:0]   count;
  logic [COUNT_W-1:0]   limit;
  logic                 too_long;
  logic [VALUE_W-1:0]   value;

  assign payload = byte_i[PAYLOAD_W-1:0];
  assign cont    = byte_i[CONT_POS];

  // 7 * seen as 8*seen - seen; seen never exceeds 9, so the result fits 6 bits
  assign shift_full = {seen_i, 3'b000} - {3'b000, seen_i};
  assign shift      = shift_full[SHIFT_W-1:0];

  assign acc_or = acc_i | ({{(VALUE_W-PAYLOAD_W){1'b0}}, payload} << shift);

  assign count    = seen_i + 4'd1;
  assign limit    = long_mode_i ? LIMIT_64 : LIMIT_32;
  assign too_long = cont && (count >= limit);

  assign value = long_mode_i ? acc_or
                             : {{(VALUE_W-WORD_W){acc_or[WORD_W-1]}}, acc_or[WORD_W-1:0]};

  always_comb begin
    result_o.emit       = !cont || too_long;
    result_o.value      = too_long ? '0 : value;
    result_o.byte_count = count;
    result_o.status     = too_long ? STATUS_TOO_LONG : STATUS_OK;
  end

  assign acc_nxt_o  = result_o.emit ? '0 : acc_or;
  assign seen_nxt_o = result_o.emit ? '0 : count;

endmodule

/* rtl/varint_stream_decoder_core.sv */
// Top level of the unsigned LEB128 varint / varlong stream decoder.
// Depends on vsd_pkg and vsd_step.
//
// Usage:
//   in_*  : one encoded byte per item in in_tdata[7:0]; bit 7 continues the value.
//   out_* : one item per finished value. out_tdata holds value (bits 63:0),
//           byte_count (bits 67:64) and zero padding; out_tuser is status
//           (0 value complete, 1 encoding too long, value then reads zero).
//   cfg_* : cfg_wr_en writes cfg_wr_data into long_mode (0 = 32-bit varint,
//           up to 5 bytes, sign-extended from bit 31; 1 = 64-bit varlong, up
//           to 10 bytes). Write only while the decoder is idle.
// Timing: an accepted byte is held in the input register, then the
//   step logic (one 64-bit shift-or and a 4-bit compare) updates the
//   accumulator; the last byte of a value loads the result register, which
//   raises out_tvalid. One byte per cycle is sustained unless out_tready stalls.
// Stall: while out_tvalid waits on out_tready, one more byte is held in the
//   input register; a continuing byte still passes through, and in_tready
//   drops only when the held byte would need the busy result register.
// Reset (rst_n low, synchronous): accumulator and byte count clear, both
//   registers empty, long_mode returns to 0.
module varint_stream_decoder_core
  import vsd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [BYTE_W-1:0]     in_tdata,    // [7:0] in_byte
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,   // [63:0] value, [67:64] byte_count, pad
  output logic                  out_tuser,   // [0] status
  input  logic                  cfg_wr_en,
  input  logic                  cfg_wr_data  // long_mode
);

  logic                 long_mode_r;
  logic                 in_valid_r, in_valid_nxt;
  logic [BYTE_W-1:0]    in_byte_r;
  logic [VALUE_W-1:0]   acc_r, acc_nxt;
  logic [COUNT_W-1:0]   seen_r, seen_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [VALUE_W-1:0]   value_r;
  logic [COUNT_W-1:0]   byte_count_r;
  vsd_status_t          status_r;
  vsd_result_t          step_res;
  logic                 out_free;
  logic                 fire;
  logic                 in_accept;

  vsd_step u_step (
    .byte_i      (in_byte_r),
    .acc_i       (acc_r),
    .seen_i      (seen_r),
    .long_mode_i (long_mode_r),
    .acc_nxt_o   (acc_nxt),
    .seen_nxt_o  (seen_nxt),
    .result_o    (step_res)
  );

  // Held byte moves on unless it makes a result and the result slot is busy
  assign out_free  = !out_valid_r || out_tready;
  assign fire      = in_valid_r && (!step_res.emit || out_free);
  assign in_tready = !in_valid_r || fire;
  assign in_accept = in_tvalid && in_tready;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_accept) begin
      in_valid_nxt = 1'b1;
    end else if (fire) begin
      in_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (fire && step_res.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      long_mode_r <= 1'b0;
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      acc_r       <= '0;
      seen_r      <= '0;
    end else begin
      if (cfg_wr_en) begin
        long_mode_r <= cfg_wr_data;
      end
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (fire) begin
        acc_r  <= acc_nxt;
        seen_r <= seen_nxt;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_accept) begin
      in_byte_r <= in_tdata;
    end
    if (fire && step_res.emit) begin
      value_r      <= step_res.value;
      byte_count_r <= step_res.byte_count;
      status_r     <= step_res.status;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{OUT_PAD_W{1'b0}}, byte_count_r, value_r};
  assign out_tuser  = status_r;

endmodule

/* rtl/vsd_checker.sv */
// Port-level checks for varint_stream_decoder_core, attached by bind.
// Depends on vsd_pkg.
module vsd_checker
  import vsd_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic                  out_tuser
);

  // Nothing can come out in the cycle after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // Byte count always within 1..10
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[67:64] != 4'd0) && (out_tdata[67:64] <= LIMIT_64))
    else $error("byte count out of range");

  // A too-long error carries a zero value and a count of at least LIMIT_32
  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |->
      (out_tdata[VALUE_W-1:0] == '0) &&
      ((out_tdata[67:64] == LIMIT_32) || (out_tdata[67:64] >= LIMIT_32)))
    else $error("too-long result with nonzero value or short count");

  // Stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=>
      out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

endmodule

bind varint_stream_decoder_core vsd_checker u_vsd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
